[rtl/palette_tinted_hsv_to_rgb_macros.svh]
// Assertion macros for the palette tinted HSV to RGB block.
`ifndef PALETTE_TINTED_HSV_TO_RGB_MACROS_SVH
`define PALETTE_TINTED_HSV_TO_RGB_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off while in reset.
`define PTHR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pthr: assertion failed");

// Next-cycle implication, sampled on the rising clock, off while in reset.
`define PTHR_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pthr: assertion failed");

`endif

[rtl/pthr_pkg.sv]
package pthr_pkg;

  // Parameter defaults
  localparam int unsigned PALETTE_COUNT_DEF    = 16;
  localparam int unsigned SINE_TABLE_DEPTH_DEF = 1024;
  localparam int unsigned FRAC_BITS_DEF        = 15;

  // Tint ROM geometry
  localparam int unsigned TINT_ROWS = 16;

  // Sine series constants in Q2.30
  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned ONE_Q30     = 64'd1 << 30;

  // Request payload
  typedef struct packed {
    logic [3:0]  palette_select;
    logic [15:0] hue_fraction;
    logic [15:0] saturation_in;
    logic [15:0] value_in;
    logic [7:0]  alpha_in;
  } pthr_in_t;

  // Result payload
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha_out;
  } pthr_out_t;

  // One palette row, all fields in thousandths
  typedef struct packed {
    logic [9:0] base_milli;
    logic [9:0] span_milli;
    logic [9:0] sat_milli;
    logic [9:0] floor_milli;
  } tint_row_t;

  localparam tint_row_t TINT_ROM [TINT_ROWS] = '{
    '{10'd0,   10'd0,   10'd0,   10'd1000},
    '{10'd0,   10'd0,   10'd760, 10'd780},
    '{10'd75,  10'd0,   10'd780, 10'd780},
    '{10'd145, 10'd0,   10'd720, 10'd800},
    '{10'd340, 10'd0,   10'd720, 10'd760},
    '{10'd600, 10'd0,   10'd720, 10'd780},
    '{10'd700, 10'd0,   10'd680, 10'd760},
    '{10'd790, 10'd0,   10'd680, 10'd780},
    '{10'd505, 10'd0,   10'd780, 10'd820},
    '{10'd875, 10'd0,   10'd760, 10'd780},
    '{10'd570, 10'd0,   10'd50,  10'd700},
    '{10'd105, 10'd0,   10'd820, 10'd700},
    '{10'd940, 10'd0,   10'd580, 10'd780},
    '{10'd305, 10'd65,  10'd860, 10'd480},
    '{10'd485, 10'd95,  10'd420, 10'd720},
    '{10'd0,   10'd150, 10'd900, 10'd620}
  };

  // Round thousandths to a fixed point value with frac fraction bits
  function automatic longint unsigned milli_to_q(input int unsigned m,
                                                 input int unsigned frac);
    return ((64'(m) << frac) + 64'd500) / 64'd1000;
  endfunction

  // sin(pi/2 * y/16384) for y in 0..16384, unsigned Q1.15, 9th order series
  function automatic logic [15:0] quarter_sine(input logic [14:0] y);
    longint unsigned th;
    longint unsigned x2;
    longint unsigned acc;
    longint unsigned s;
    longint unsigned r;
    th  = (64'(y) * HALF_PI_Q30) >> 14;
    x2  = (th * th) >> 30;
    acc = ONE_Q30 - x2 / 64'd72;
    acc = ONE_Q30 - ((x2 * acc) >> 30) / 64'd42;
    acc = ONE_Q30 - ((x2 * acc) >> 30) / 64'd20;
    acc = ONE_Q30 - ((x2 * acc) >> 30) / 64'd6;
    s   = (th * acc) >> 30;
    r   = (s + 64'd16384) >> 15;
    if (r > 64'd32768) begin
      r = 64'd32768;
    end
    return 16'(r);
  endfunction

  // Shade 0.5 + 0.5*sin(2*pi*phase) in Q1.15 for a Q0.16 phase
  function automatic logic [15:0] shade_of_phase(input logic [15:0] phase);
    logic [1:0]  quad;
    logic [14:0] arg;
    logic [15:0] mag;
    logic [16:0] sum;
    quad = phase[15:14];
    arg  = quad[0] ? 15'd16384 - 15'(phase[13:0]) : 15'(phase[13:0]);
    mag  = quarter_sine(arg);
    sum  = quad[1] ? 17'd32768 - 17'(mag) : 17'd32768 + 17'(mag);
    return sum[16:1];
  endfunction

endpackage

[rtl/palette_tinted_hsv_to_rgb.sv]
// Channel   Direction  Handshake                 Payload
// request   in         in_valid_i / in_stall_o   in_data_i  (pthr_pkg::pthr_in_t)
// result    out        out_valid_o / out_stall_i out_data_o (pthr_pkg::pthr_out_t)
//
// Seven register stages; one request enters per cycle while in_stall_o is low.
// The stages hold the registered shade ROM read, the scale and value
// products, and the wide hexcone product, which is split into two partial
// products summed one stage later. Reset clears only the stage valid bits.
// A stalled result holds the last stage; earlier stages keep filling bubbles,
// and in_stall_o rises only when every stage holds a request.
module palette_tinted_hsv_to_rgb #(
  parameter int unsigned PALETTE_COUNT    = pthr_pkg::PALETTE_COUNT_DEF,
  parameter int unsigned SINE_TABLE_DEPTH = pthr_pkg::SINE_TABLE_DEPTH_DEF,
  parameter int unsigned FRAC_BITS        = pthr_pkg::FRAC_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  pthr_pkg::pthr_in_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output pthr_pkg::pthr_out_t out_data_o
);

  // Widths
  localparam int unsigned QW     = FRAC_BITS + 1;       // sat, value, scale
  localparam int unsigned WIDE   = 16 + FRAC_BITS;      // Q1.15 rescale
  localparam int unsigned AW     = $clog2(SINE_TABLE_DEPTH);
  localparam int unsigned DW     = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int unsigned LW     = 17;                  // low term slice
  localparam int unsigned UW     = FRAC_BITS + 17;      // positive term
  localparam int unsigned HW     = UW - LW;             // high term slice
  localparam int unsigned TW     = FRAC_BITS + 18;      // signed term
  localparam int unsigned XW     = QW + UW;             // value times term
  localparam int unsigned YW     = XW + 8;              // times 255
  localparam int unsigned SH     = 2 * FRAC_BITS + 16;  // channel shift
  localparam int unsigned NSTAGE = 7;
  localparam int unsigned NCH    = 3;

  // Constants
  localparam logic [QW-1:0]        Q_ONE     = QW'(longint'(1) << FRAC_BITS);
  localparam logic signed [TW-1:0] T_ONE     = TW'(longint'(1) << (FRAC_BITS + 16));
  localparam logic [16:0]          TURN      = 17'h1_0000;
  localparam logic [4:0]           PAL_LIMIT = 5'(PALETTE_COUNT);
  localparam logic [DW-1:0]        DEPTH_K   = DW'(SINE_TABLE_DEPTH);

  // Channel lanes
  localparam int unsigned CH_R = 0;
  localparam int unsigned CH_G = 1;
  localparam int unsigned CH_B = 2;

  // Hexcone sectors
  localparam logic [2:0] SEC_RED     = 3'd0;
  localparam logic [2:0] SEC_YELLOW  = 3'd1;
  localparam logic [2:0] SEC_GREEN   = 3'd2;
  localparam logic [2:0] SEC_CYAN    = 3'd3;
  localparam logic [2:0] SEC_BLUE    = 3'd4;
  localparam logic [2:0] SEC_MAGENTA = 3'd5;

  // ROM types
  typedef logic [QW-1:0] qtab_t [pthr_pkg::TINT_ROWS];
  typedef logic [15:0]   htab_t [pthr_pkg::TINT_ROWS];
  typedef logic [15:0]   shade_tab_t [SINE_TABLE_DEPTH];

  function automatic qtab_t build_sat_rom();
    qtab_t tab;
    for (int i = 0; i < pthr_pkg::TINT_ROWS; i++) begin
      tab[i] = QW'(pthr_pkg::milli_to_q(pthr_pkg::TINT_ROM[i].sat_milli, FRAC_BITS));
    end
    return tab;
  endfunction

  function automatic qtab_t build_floor_rom();
    qtab_t tab;
    for (int i = 0; i < pthr_pkg::TINT_ROWS; i++) begin
      tab[i] = QW'(pthr_pkg::milli_to_q(pthr_pkg::TINT_ROM[i].floor_milli, FRAC_BITS));
    end
    return tab;
  endfunction

  function automatic htab_t build_base_rom();
    htab_t tab;
    for (int i = 0; i < pthr_pkg::TINT_ROWS; i++) begin
      tab[i] = 16'(pthr_pkg::milli_to_q(pthr_pkg::TINT_ROM[i].base_milli, 16));
    end
    return tab;
  endfunction

  function automatic htab_t build_span_rom();
    htab_t tab;
    for (int i = 0; i < pthr_pkg::TINT_ROWS; i++) begin
      tab[i] = 16'(pthr_pkg::milli_to_q(pthr_pkg::TINT_ROM[i].span_milli, 16));
    end
    return tab;
  endfunction

  // Shade per table entry, taken at the entry's phase
  function automatic shade_tab_t build_shade_rom();
    shade_tab_t      tab;
    longint unsigned ph;
    for (int i = 0; i < SINE_TABLE_DEPTH; i++) begin
      ph     = (64'(i) << 16) / SINE_TABLE_DEPTH;
      tab[i] = pthr_pkg::shade_of_phase(16'(ph));
    end
    return tab;
  endfunction

  localparam qtab_t      SAT_ROM   = build_sat_rom();
  localparam qtab_t      FLOOR_ROM = build_floor_rom();
  localparam htab_t      BASE_ROM  = build_base_rom();
  localparam htab_t      SPAN_ROM  = build_span_rom();
  localparam shade_tab_t SHADE_ROM = build_shade_rom();

  // ---------------------------------------------------------------------
  // Flow control
  // ---------------------------------------------------------------------
  logic [NSTAGE-1:0] vld_q;
  logic [NSTAGE-1:0] vld_d;
  logic [NSTAGE-1:0] adv;

  // Let a stage load when it is empty or the stage ahead moves
  always_comb begin
    adv[NSTAGE-1] = !vld_q[NSTAGE-1] || !out_stall_i;
    for (int k = NSTAGE - 2; k >= 0; k--) begin
      adv[k] = !vld_q[k] || adv[k+1];
    end
  end

  always_comb begin
    vld_d[0] = adv[0] ? in_valid_i : vld_q[0];
    for (int k = 1; k < NSTAGE; k++) begin
      vld_d[k] = adv[k] ? vld_q[k-1] : vld_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  assign in_stall_o  = !adv[0];
  assign out_valid_o = vld_q[NSTAGE-1];

  // ---------------------------------------------------------------------
  // Stage 1: palette lookup, tinted hue, input rescale, shade ROM read
  // ---------------------------------------------------------------------
  logic [3:0]       pal;
  logic             tint_d;
  logic [31:0]      hspan_prod;
  logic [15:0]      hue1_d;
  logic [WIDE-1:0]  sat_w;
  logic [WIDE-1:0]  val_w;
  logic [QW-1:0]    sat1_d;
  logic [16+DW-1:0] addr_prod;
  logic [AW-1:0]    shade_addr;

  assign pal        = in_data_i.palette_select;
  assign tint_d     = (pal != '0) && ({1'b0, pal} < PAL_LIMIT);
  assign hspan_prod = in_data_i.hue_fraction * SPAN_ROM[pal];
  assign hue1_d     = tint_d ? BASE_ROM[pal] + hspan_prod[31:16]
                             : in_data_i.hue_fraction;
  assign sat_w      = WIDE'(in_data_i.saturation_in) << FRAC_BITS;
  assign val_w      = WIDE'(in_data_i.value_in) << FRAC_BITS;
  assign sat1_d     = tint_d ? SAT_ROM[pal] : sat_w[15 +: QW];
  assign addr_prod  = in_data_i.hue_fraction * DEPTH_K;
  assign shade_addr = addr_prod[16 +: AW];

  logic          tint_s1_q;
  logic [15:0]   hue_s1_q;
  logic [QW-1:0] sat_s1_q;
  logic [QW-1:0] val_s1_q;
  logic [QW-1:0] flr_s1_q;
  logic [15:0]   shade_s1_q;
  logic [7:0]    alpha_s1_q;

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      tint_s1_q  <= tint_d;
      hue_s1_q   <= hue1_d;
      sat_s1_q   <= sat1_d;
      val_s1_q   <= val_w[15 +: QW];
      flr_s1_q   <= FLOOR_ROM[pal];
      shade_s1_q <= SHADE_ROM[shade_addr];
      alpha_s1_q <= in_data_i.alpha_in;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 2: brightness scale from floor and shade, hexcone sector
  // ---------------------------------------------------------------------
  logic [WIDE-1:0] shade_w;
  logic [QW-1:0]   shade_fb;
  logic [2*QW-1:0] flr_prod;
  logic [QW:0]     scale_sum;
  logic [18:0]     hue6;

  assign shade_w   = WIDE'(shade_s1_q) << FRAC_BITS;
  assign shade_fb  = shade_w[15 +: QW];
  assign flr_prod  = (Q_ONE - flr_s1_q) * shade_fb;
  assign scale_sum = (QW+1)'(flr_s1_q) + (QW+1)'(flr_prod[FRAC_BITS +: QW]);
  assign hue6      = hue_s1_q * 19'd6;

  logic          tint_s2_q;
  logic [QW-1:0] sat_s2_q;
  logic [QW-1:0] val_s2_q;
  logic [QW-1:0] scale_s2_q;
  logic [2:0]    sector_s2_q;
  logic [15:0]   frac_s2_q;
  logic [7:0]    alpha_s2_q;

  always_ff @(posedge clk_i) begin
    if (adv[1]) begin
      tint_s2_q   <= tint_s1_q;
      sat_s2_q    <= sat_s1_q;
      val_s2_q    <= val_s1_q;
      scale_s2_q  <= scale_sum[QW-1:0];
      sector_s2_q <= hue6[18:16];
      frac_s2_q   <= hue6[15:0];
      alpha_s2_q  <= alpha_s1_q;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 3: scaled value, saturation times fraction and its complement
  // ---------------------------------------------------------------------
  logic [2*QW-1:0] v_prod;
  logic [16:0]     frac_c;
  logic [QW+15:0]  wq_d;
  logic [QW+16:0]  wt_d;

  assign v_prod = val_s2_q * scale_s2_q;
  assign frac_c = TURN - 17'(frac_s2_q);
  assign wq_d   = sat_s2_q * frac_s2_q;
  assign wt_d   = sat_s2_q * frac_c;

  logic [QW-1:0]  val_s3_q;
  logic [QW-1:0]  sat_s3_q;
  logic [QW+15:0] wq_s3_q;
  logic [QW+16:0] wt_s3_q;
  logic [2:0]     sector_s3_q;
  logic [7:0]     alpha_s3_q;

  always_ff @(posedge clk_i) begin
    if (adv[2]) begin
      val_s3_q    <= tint_s2_q ? v_prod[FRAC_BITS +: QW] : val_s2_q;
      sat_s3_q    <= sat_s2_q;
      wq_s3_q     <= wq_d;
      wt_s3_q     <= wt_d;
      sector_s3_q <= sector_s2_q;
      alpha_s3_q  <= alpha_s2_q;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 4: form p, q, t, v terms and route them to the channels
  // ---------------------------------------------------------------------
  logic signed [TW-1:0] tp;
  logic signed [TW-1:0] tq;
  logic signed [TW-1:0] tt;
  logic signed [TW-1:0] term [NCH];
  logic [UW-1:0]        mag_d [NCH];
  logic [NCH-1:0]       pos_d;

  assign tp = T_ONE - (TW'(sat_s3_q) << 16);
  assign tq = T_ONE - TW'(wq_s3_q);
  assign tt = T_ONE - TW'(wt_s3_q);

  always_comb begin
    case (sector_s3_q)
      SEC_YELLOW: begin
        term[CH_R] = tq;
        term[CH_G] = T_ONE;
        term[CH_B] = tp;
      end
      SEC_GREEN: begin
        term[CH_R] = tp;
        term[CH_G] = T_ONE;
        term[CH_B] = tt;
      end
      SEC_CYAN: begin
        term[CH_R] = tp;
        term[CH_G] = tq;
        term[CH_B] = T_ONE;
      end
      SEC_BLUE: begin
        term[CH_R] = tt;
        term[CH_G] = tp;
        term[CH_B] = T_ONE;
      end
      SEC_MAGENTA: begin
        term[CH_R] = T_ONE;
        term[CH_G] = tp;
        term[CH_B] = tq;
      end
      SEC_RED: begin
        term[CH_R] = T_ONE;
        term[CH_G] = tt;
        term[CH_B] = tp;
      end
      default: begin
        term[CH_R] = T_ONE;
        term[CH_G] = tt;
        term[CH_B] = tp;
      end
    endcase
  end

  // Keep the magnitude of a positive term; flag the rest to clamp to zero
  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      mag_d[c] = term[c][UW-1:0];
      pos_d[c] = !term[c][TW-1] && (term[c] != '0);
    end
  end

  logic [UW-1:0]  mag_s4_q [NCH];
  logic [NCH-1:0] pos_s4_q;
  logic [QW-1:0]  val_s4_q;
  logic [7:0]     alpha_s4_q;

  always_ff @(posedge clk_i) begin
    if (adv[3]) begin
      for (int c = 0; c < NCH; c++) begin
        mag_s4_q[c] <= mag_d[c];
      end
      pos_s4_q   <= pos_d;
      val_s4_q   <= val_s3_q;
      alpha_s4_q <= alpha_s3_q;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 5: value times term, as low and high partial products
  // ---------------------------------------------------------------------
  logic [QW+LW-1:0] pp_lo_d [NCH];
  logic [QW+HW-1:0] pp_hi_d [NCH];

  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      pp_lo_d[c] = val_s4_q * mag_s4_q[c][LW-1:0];
      pp_hi_d[c] = val_s4_q * mag_s4_q[c][UW-1:LW];
    end
  end

  logic [QW+LW-1:0] pp_lo_s5_q [NCH];
  logic [QW+HW-1:0] pp_hi_s5_q [NCH];
  logic [NCH-1:0]   pos_s5_q;
  logic [7:0]       alpha_s5_q;

  always_ff @(posedge clk_i) begin
    if (adv[4]) begin
      for (int c = 0; c < NCH; c++) begin
        pp_lo_s5_q[c] <= pp_lo_d[c];
        pp_hi_s5_q[c] <= pp_hi_d[c];
      end
      pos_s5_q   <= pos_s4_q;
      alpha_s5_q <= alpha_s4_q;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 6: sum the partial products
  // ---------------------------------------------------------------------
  logic [XW-1:0] x_d [NCH];

  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      x_d[c] = XW'(pp_lo_s5_q[c]) + (XW'(pp_hi_s5_q[c]) << LW);
    end
  end

  logic [XW-1:0]  x_s6_q [NCH];
  logic [NCH-1:0] pos_s6_q;
  logic [7:0]     alpha_s6_q;

  always_ff @(posedge clk_i) begin
    if (adv[5]) begin
      for (int c = 0; c < NCH; c++) begin
        x_s6_q[c] <= x_d[c];
      end
      pos_s6_q   <= pos_s5_q;
      alpha_s6_q <= alpha_s5_q;
    end
  end

  // ---------------------------------------------------------------------
  // Stage 7: times 255, drop fraction, saturate, output register
  // ---------------------------------------------------------------------
  logic [YW-1:0]       y [NCH];
  logic [9:0]          chan [NCH];
  logic [7:0]          byte_d [NCH];
  pthr_pkg::pthr_out_t out_data_d;
  pthr_pkg::pthr_out_t out_data_q;

  always_comb begin
    for (int c = 0; c < NCH; c++) begin
      y[c]    = (YW'(x_s6_q[c]) << 8) - YW'(x_s6_q[c]);
      chan[c] = y[c][SH +: 10];
      if (!pos_s6_q[c]) begin
        byte_d[c] = 8'd0;
      end else if (chan[c] > 10'd255) begin
        byte_d[c] = 8'hFF;
      end else begin
        byte_d[c] = chan[c][7:0];
      end
    end
  end

  always_comb begin
    out_data_d.red       = byte_d[CH_R];
    out_data_d.green     = byte_d[CH_G];
    out_data_d.blue      = byte_d[CH_B];
    out_data_d.alpha_out = alpha_s6_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv[6]) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_data_o = out_data_q;

endmodule

[rtl/pthr_check.sv]
`include "palette_tinted_hsv_to_rgb_macros.svh"

// Port-level checks for the palette tinted HSV to RGB pipeline.
module pthr_check (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input pthr_pkg::pthr_out_t out_data_o
);

  // Hold a stalled result and its payload
  `PTHR_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o && $stable(out_data_o))

  // Stall requests only under back pressure from a waiting result
  `PTHR_ASSERT_IMP(a_stall_cause, clk_i, rst_ni, in_stall_o, out_valid_o && out_stall_i)

  // Deliver an accepted request at the output when nothing stalls it
  `PTHR_ASSERT_NXT(a_latency, clk_i, rst_ni, (in_valid_i && !in_stall_o) ##1 !out_stall_i ##1 !out_stall_i ##1 !out_stall_i ##1 !out_stall_i ##1 !out_stall_i ##1 !out_stall_i, out_valid_o)

endmodule

bind palette_tinted_hsv_to_rgb pthr_check u_pthr_check (.*);
